// File: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// File: hdl/rpn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_pkg
// Types and codes shared by the RPN stack calculator modules.
// ----------------------------------------------------------------------------
package rpn_pkg;
   localparam logic [3:0] MODE_PUSH  = 4'd0;
   localparam logic [3:0] MODE_ADD   = 4'd1;
   localparam logic [3:0] MODE_SUB   = 4'd2;
   localparam logic [3:0] MODE_MUL   = 4'd3;
   localparam logic [3:0] MODE_DIV   = 4'd4;
   localparam logic [3:0] MODE_MOD   = 4'd5;
   localparam logic [3:0] MODE_PRINT = 4'd6;
   localparam logic [3:0] MODE_POP   = 4'd7;
   localparam logic [3:0] MODE_CLEAR = 4'd8;
   localparam logic [3:0] MODE_DUP   = 4'd9;
   localparam logic [3:0] MODE_SWAP  = 4'd10;
   localparam logic [3:0] MODE_PALL  = 4'd11;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_NEED2 = 3'd3;
   localparam logic [2:0] ST_DIVZ  = 3'd4;
   localparam logic [2:0] ST_BAD   = 3'd5;

   typedef struct packed {
      logic [3:0]         mode;
      logic signed [31:0] operand;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               has_value;
      logic [2:0]         status;
      logic [6:0]         depth;
      logic               last;
   } rsp_type;

   // datapath operations issued by the controller
   localparam logic [2:0] OP_NONE  = 3'd0;
   localparam logic [2:0] OP_RDTOP = 3'd1; // read top (n-1) and next (n-2)
   localparam logic [2:0] OP_RDIDX = 3'd2; // read entry at walk index
   localparam logic [2:0] OP_ALU   = 3'd3; // start alu on latched operands
   localparam logic [2:0] OP_WRA   = 3'd4; // write result to n-2
   localparam logic [2:0] OP_SWAP1 = 3'd5; // write b to n-2
   localparam logic [2:0] OP_SWAP2 = 3'd6; // write a to n-1
   localparam logic [2:0] OP_WRN   = 3'd7; // write push data / dup data to n

   typedef struct packed {
      logic [2:0] op;
      logic [6:0] addr;    // walk index or count snapshot
      logic [3:0] mode;
      logic       use_opnd;
   } dp_cmd_type;

   typedef struct packed {
      logic alu_done;
      logic b_zero;
   } dp_status_type;
endpackage

// File: hdl/rpn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_datapath
// Stack memory, operand registers, adder/multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module rpn_datapath #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  rpn_pkg::dp_cmd_type      cmd,
   input  logic [31:0]              opnd,
   output rpn_pkg::dp_status_type   stat,
   output logic [VALUE_BITS-1:0]    rd_data,
   output logic [VALUE_BITS-1:0]    a_out
);
   import rpn_pkg::*;
   localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CW = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0] mem [STACK_DEPTH];
   logic [VALUE_BITS-1:0] a_ff, b_ff, res_ff, rd_ff;
   logic [VALUE_BITS-1:0] q_ff, q_in, rem_ff, rem_in, mb_ff;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  busy_ff, busy_in, done_ff, done_in;

   logic [AW-1:0] top_addr, next_addr, rd_addr;
   logic [VALUE_BITS-1:0] wdata;
   logic [AW-1:0]         waddr;
   logic                  we;
   logic [VALUE_BITS-1:0] mag_a, mag_b;
   logic [VALUE_BITS:0]   trial;
   logic                  neg_a, neg_b;

   function automatic logic [VALUE_BITS-1:0] quo_sel(input logic [VALUE_BITS-1:0] q);
      return (neg_a != neg_b) ? -q : q;
   endfunction
   function automatic logic [VALUE_BITS-1:0] rem_fix(input logic [VALUE_BITS-1:0] r);
      return neg_a ? -r : r;
   endfunction

   assign top_addr  = AW'(cmd.addr - 7'd1);
   assign next_addr = AW'(cmd.addr - 7'd2);
   // one shared address for the top read and the walk read
   assign rd_addr   = (cmd.op == OP_RDIDX) ? AW'(cmd.addr) : top_addr;
   assign neg_a = a_ff[VALUE_BITS-1];
   assign neg_b = b_ff[VALUE_BITS-1];
   assign mag_a = neg_a ? -a_ff : a_ff;
   assign mag_b = neg_b ? -b_ff : b_ff;

   // write port
   always_comb begin
      we = 1'b1;
      waddr = top_addr;
      wdata = b_ff;
      unique case (cmd.op)
         OP_WRA: begin
            waddr = next_addr;
            wdata = res_ff;
         end
         OP_SWAP1: begin
            waddr = next_addr;
            wdata = b_ff;
         end
         OP_SWAP2: begin
            waddr = top_addr;
            wdata = a_ff;
         end
         OP_WRN: begin
            waddr = AW'(cmd.addr);
            wdata = cmd.use_opnd ? VALUE_BITS'($signed(opnd)) : b_ff;
         end
         default: we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // reads: top (or walk index) on the first port, next on the second
   always_ff @(posedge clock) begin
      if (cmd.op == OP_RDTOP) begin
         b_ff <= mem[rd_addr];
         a_ff <= mem[next_addr];
      end
      if (cmd.op == OP_RDIDX) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // divider: restoring, one quotient bit per cycle
   always_comb begin
      q_in = q_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = '0;
      if (cmd.op == OP_ALU && !busy_ff) begin
         if (cmd.mode == MODE_DIV || cmd.mode == MODE_MOD) begin
            q_in = mag_a;
            rem_in = '0;
            cnt_in = CW'(VALUE_BITS);
            busy_in = 1'b1;
         end else begin
            done_in = 1'b1;
         end
      end else if (busy_ff) begin
         trial = {rem_ff, q_ff[VALUE_BITS-1]} - {1'b0, mb_ff};
         if (!trial[VALUE_BITS]) begin
            rem_in = trial[VALUE_BITS-1:0];
            q_in = {q_ff[VALUE_BITS-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[VALUE_BITS-2:0], q_ff[VALUE_BITS-1]};
            q_in = {q_ff[VALUE_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff   <= q_in;
      rem_ff <= rem_in;
      if (cmd.op == OP_ALU && !busy_ff) begin
         mb_ff <= mag_b;
      end
   end

   // result register, written at the same edge as the done flag
   always_ff @(posedge clock) begin
      if (cmd.op == OP_ALU && !busy_ff) begin
         unique case (cmd.mode)
            MODE_ADD: res_ff <= a_ff + b_ff;
            MODE_SUB: res_ff <= a_ff - b_ff;
            MODE_MUL: res_ff <= VALUE_BITS'(a_ff * b_ff);
            default:  res_ff <= res_ff;
         endcase
      end else if (done_in && busy_ff) begin
         res_ff <= (cmd.mode == MODE_DIV) ? quo_sel(q_in) : rem_fix(rem_in);
      end
   end

   assign stat.alu_done = done_ff;
   assign stat.b_zero   = (b_ff == '0);
   assign rd_data = rd_ff;
   assign a_out   = b_ff; // top of stack for print, pop and dup
endmodule

// File: hdl/rpn_control.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_control
// Command sequencer: checks, drives datapath steps and emits responses.
// ----------------------------------------------------------------------------
module rpn_control #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  rpn_pkg::req_type        req,
   output logic                    busy,
   output rpn_pkg::dp_cmd_type     cmd,
   input  rpn_pkg::dp_status_type  stat,
   input  logic [VALUE_BITS-1:0]   rd_data,
   input  logic [VALUE_BITS-1:0]   top_data,
   output logic                    strobe,
   output rpn_pkg::rsp_type        rsp
);
   import rpn_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_RD    = 4'd1;  // operand registers loaded, wait state
   localparam logic [3:0] S_EXEC  = 4'd2;  // operands valid
   localparam logic [3:0] S_ALU   = 4'd3;  // waiting alu
   localparam logic [3:0] S_WR    = 4'd4;  // write result
   localparam logic [3:0] S_SWAP2 = 4'd5;
   localparam logic [3:0] S_WALK  = 4'd6;  // issue read of walk index
   localparam logic [3:0] S_WOUT  = 4'd7;  // walk data valid
   localparam logic [3:0] S_DUPW  = 4'd8;  // dup write; never entered, dup writes from S_EXEC

   logic [3:0] state_ff, state_in;
   logic [3:0] mode_ff, mode_in;
   logic [6:0] n_ff, n_in, idx_ff, idx_in;
   logic       strobe_ff, strobe_in;
   rsp_type    rsp_ff, rsp_in;
   localparam logic [6:0] FULL = 7'(STACK_DEPTH);

   function automatic logic [31:0] ext(input logic [VALUE_BITS-1:0] v);
      return 32'($signed(v));
   endfunction

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      n_in = n_ff;
      idx_in = idx_ff;
      strobe_in = 1'b0;
      rsp_in = rsp_ff;
      cmd = '0;
      cmd.mode = mode_ff;
      cmd.addr = n_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in = req.mode;
               rsp_in = '0;
               rsp_in.last = 1'b1;
               rsp_in.depth = n_ff;
               unique case (req.mode)
                  MODE_PUSH: begin
                     if (n_ff >= FULL) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        cmd.op = OP_WRN;
                        cmd.use_opnd = 1'b1;
                        n_in = n_ff + 7'd1;
                        rsp_in.depth = n_in;
                     end
                     strobe_in = 1'b1;
                  end
                  MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_MOD, MODE_SWAP: begin
                     if (n_ff < 7'd2) begin
                        rsp_in.status = ST_NEED2;
                        strobe_in = 1'b1;
                     end else begin
                        cmd.op = OP_RDTOP;
                        state_in = S_RD;
                     end
                  end
                  MODE_PRINT, MODE_POP: begin
                     if (n_ff == 7'd0) begin
                        rsp_in.status = ST_EMPTY;
                        strobe_in = 1'b1;
                     end else begin
                        cmd.op = OP_RDTOP;
                        state_in = S_RD;
                     end
                  end
                  MODE_DUP: begin
                     if (n_ff == 7'd0) begin
                        rsp_in.status = ST_EMPTY;
                        strobe_in = 1'b1;
                     end else if (n_ff >= FULL) begin
                        rsp_in.status = ST_FULL;
                        strobe_in = 1'b1;
                     end else begin
                        cmd.op = OP_RDTOP;
                        state_in = S_RD;
                     end
                  end
                  MODE_CLEAR: begin
                     n_in = 7'd0;
                     rsp_in.depth = 7'd0;
                     strobe_in = 1'b1;
                  end
                  MODE_PALL: begin
                     if (n_ff == 7'd0) begin
                        strobe_in = 1'b1;
                     end else begin
                        idx_in = n_ff - 7'd1;
                        state_in = S_WALK;
                     end
                  end
                  default: begin
                     rsp_in.status = ST_BAD;
                     strobe_in = 1'b1;
                  end
               endcase
            end
         end
         S_RD: state_in = S_EXEC;
         S_EXEC: begin
            unique case (mode_ff)
               MODE_SWAP: begin
                  cmd.op = OP_SWAP1;
                  state_in = S_SWAP2;
               end
               MODE_PRINT, MODE_POP: begin
                  rsp_in.value = ext(top_data);
                  rsp_in.has_value = 1'b1;
                  if (mode_ff == MODE_POP) begin
                     n_in = n_ff - 7'd1;
                  end
                  rsp_in.depth = n_in;
                  strobe_in = 1'b1;
                  state_in = S_IDLE;
               end
               MODE_DUP: begin
                  cmd.op = OP_WRN;
                  n_in = n_ff + 7'd1;
                  rsp_in.value = ext(top_data);
                  rsp_in.has_value = 1'b1;
                  rsp_in.depth = n_in;
                  strobe_in = 1'b1;
                  state_in = S_IDLE;
               end
               default: begin
                  if ((mode_ff == MODE_DIV || mode_ff == MODE_MOD) && stat.b_zero) begin
                     rsp_in.status = ST_DIVZ;
                     strobe_in = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     cmd.op = OP_ALU;
                     state_in = S_ALU;
                  end
               end
            endcase
         end
         S_ALU: begin
            if (stat.alu_done) begin
               state_in = S_WR;
            end
         end
         S_WR: begin
            cmd.op = OP_WRA;
            n_in = n_ff - 7'd1;
            rsp_in.depth = n_in;
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         S_SWAP2: begin
            cmd.op = OP_SWAP2;
            strobe_in = 1'b1;
            state_in = S_IDLE;
         end
         S_WALK: begin
            cmd.op = OP_RDIDX;
            cmd.addr = idx_ff;
            state_in = S_WOUT;
         end
         S_WOUT: begin
            rsp_in.value = ext(rd_data);
            rsp_in.has_value = 1'b1;
            rsp_in.last = (idx_ff == 7'd0);
            strobe_in = 1'b1;
            if (idx_ff == 7'd0) begin
               state_in = S_IDLE;
            end else begin
               idx_in = idx_ff - 7'd1;
               cmd.op = OP_RDIDX;
               cmd.addr = idx_in;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         n_ff <= '0;
         idx_ff <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         idx_ff <= idx_in;
         strobe_ff <= strobe_in;
      end
      mode_ff <= mode_in;
      rsp_ff <= rsp_in;
   end

   assign busy = (state_ff != S_IDLE);
   assign strobe = strobe_ff;
   assign rsp = rsp_ff;
endmodule

// File: hdl/rpn_stack_calculator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator
// Reverse-Polish integer stack engine with a bit-serial divider.
// ----------------------------------------------------------------------------
// channel  | ports                      | handshake
// request  | start, busy, req_data      | taken when start && !busy
// response | rsp_strobe, rsp_data       | one cycle per result, no backpressure
//
// Push, clear, count errors, bad mode: result the cycle after start, next item next cycle.
// Print, pop, dup, divide by zero: top read at start, S_RD, then S_EXEC responds.
// Swap adds S_SWAP2; add, sub, mul add S_ALU and S_WR. Div/mod waits in S_ALU on the
// one-bit-per-cycle divider. Print all: S_WALK, then one entry per cycle from the
// memory read port. Reset (synchronous) empties the stack; stack contents are not cleared.
module rpn_stack_calculator #(
   parameter int STACK_DEPTH = 64,
   parameter int VALUE_BITS  = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rpn_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output rpn_pkg::rsp_type  rsp_data
);
   import rpn_pkg::*;
   `include "assert_macros.svh"

   dp_cmd_type            cmd;
   dp_status_type         stat;
   logic [VALUE_BITS-1:0] rd_data, top_data;

   rpn_datapath #(.STACK_DEPTH(STACK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .opnd(req_data.operand),
      .stat(stat), .rd_data(rd_data), .a_out(top_data)
   );

   rpn_control #(.STACK_DEPTH(STACK_DEPTH), .VALUE_BITS(VALUE_BITS)) u_ctl (
      .clock(clock), .reset(reset), .start(start), .req(req_data), .busy(busy),
      .cmd(cmd), .stat(stat), .rd_data(rd_data), .top_data(top_data),
      .strobe(rsp_strobe), .rsp(rsp_data)
   );

   `ASSERT_CLK(a_depth_max, clock, reset, rsp_strobe |-> rsp_data.depth <= 7'(STACK_DEPTH), "depth over capacity")
   `ASSERT_CLK(a_noval_zero, clock, reset, (rsp_strobe && !rsp_data.has_value) |-> rsp_data.value == '0, "value without has_value")
   `ASSERT_CLK(a_err_last, clock, reset, (rsp_strobe && rsp_data.status != ST_OK) |-> rsp_data.last, "error not last")
endmodule
